### sv/vsrs_pkg.sv
// ----------------------------------------------------------------------------
// vsrs_pkg
// Shared types and constants for the valve stall rehome sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package vsrs_pkg;

    // default width of the millisecond counters
    localparam int TIME_BITS_DEF = 18;

    // register field widths
    localparam int TRAVEL_W   = 18;
    localparam int MARGIN_W   = 16;
    localparam int DEBOUNCE_W = 8;
    localparam int GAIN_W     = 16;

    // register reset values
    localparam logic [TRAVEL_W-1:0]   TRAVEL_RESET   = 18'd60000;
    localparam logic [MARGIN_W-1:0]   MARGIN_RESET   = 16'd3000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd80;
    localparam logic [GAIN_W-1:0]     GAIN_RESET     = 16'd16384;

    // apb register map
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_TRAVEL   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CAL      = 3'd4;

    // position arithmetic
    localparam int POS_W     = 14;
    localparam int GAIN_FRAC = 14;
    localparam int QUO_W     = 16;
    localparam int LO_W      = 24;
    localparam logic [POS_W-1:0] POS_FULL = 14'd10000;
    localparam logic [POS_W-1:0] POS_DONE = 14'd9990;

    localparam int STALL_W = 8;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_OPENING = 3'd1,
        PH_COMPUTE = 3'd2,
        PH_CLOSING = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DONE  = 2'd1,
        EV_ERROR = 2'd2,
        EV_SKIP  = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_STEP,
        CS_MUL_LO,
        CS_MUL_HI,
        CS_DIV_INIT,
        CS_DIV,
        CS_FIN,
        CS_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic mul;
        logic mul_lo;
        logic mul_hi;
        logic div_init;
        logic div_step;
        logic fin;
    } dp_cmd_t;

    typedef struct packed {
        logic is_compute;
        logic div_last;
    } dp_stat_t;

    typedef struct packed {
        event_t             event_res;
        logic               position_valid;
        logic [POS_W-1:0]   position;
        phase_t             phase;
        logic               drive_close;
        logic               drive_open;
    } result_t;

endpackage

`default_nettype wire

### sv/vsrs_ctrl.sv
// ----------------------------------------------------------------------------
// vsrs_ctrl
// Sequencer that steps the datapath through one item and hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module vsrs_ctrl
    import vsrs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic     out_free,
    output logic          out_load,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_STEP;
                end
            end
            CS_STEP: begin
                if (stat.is_compute) begin
                    cmd.mul    = 1'b1;
                    state_next = CS_MUL_LO;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = CS_OUT;
                end
            end
            CS_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = CS_MUL_HI;
            end
            CS_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = CS_DIV_INIT;
            end
            CS_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = CS_DIV;
            end
            CS_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = CS_FIN;
                end
            end
            CS_FIN: begin
                cmd.fin    = 1'b1;
                state_next = CS_OUT;
            end
            CS_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded while output register still full");

    a_fin_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |=> (state_reg == CS_OUT))
        else $error("finished compute not followed by result handoff");

endmodule

`default_nettype wire

### sv/vsrs_dp.sv
// ----------------------------------------------------------------------------
// vsrs_dp
// Sequence state, counters and the position multiplier and serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module vsrs_dp
    import vsrs_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic                  in_func,
    input  wire logic                  in_stall,
    input  wire logic                  in_fault,
    input  wire logic [TIME_BITS-1:0]  cfg_travel,
    input  wire logic [MARGIN_W-1:0]   cfg_margin,
    input  wire logic [DEBOUNCE_W-1:0] cfg_debounce,
    input  wire logic [GAIN_W-1:0]     cfg_gain,
    input  wire logic                  cfg_cal,
    output result_t                    result
);

    localparam int XW      = TIME_BITS + GAIN_W;
    localparam int NW      = XW + POS_W;
    localparam int HI_W    = XW - LO_W;
    localparam int LP_W    = LO_W + POS_W;
    localparam int HP_W    = HI_W + POS_W;
    localparam int SUM_W   = ((TIME_BITS > MARGIN_W) ? TIME_BITS : MARGIN_W) + 1;
    localparam int CNT_W   = $clog2(QUO_W);

    // sequence state
    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0] open_reg, open_next;
    logic [STALL_W-1:0]   stall_cnt_reg, stall_cnt_next;
    logic [POS_W-1:0]     recovered_reg, recovered_next;
    logic [POS_W-1:0]     current_reg, current_next;
    logic                 valid_reg, valid_next;
    event_t               event_reg, event_next;

    // latched input item
    logic func_reg, func_next;
    logic stall_reg, stall_next;
    logic fault_reg, fault_next;

    // arithmetic
    logic [XW-1:0]        x_reg, x_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [TIME_BITS-1:0] diff;
    logic [XW-1:0]        x_prod;
    logic [LP_W-1:0]      lo_prod;
    logic [HP_W-1:0]      hi_prod;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   divisor;
    logic [TIME_BITS-1:0] el_inc;
    logic [STALL_W-1:0]   sc_new;
    logic                 stall_hit;
    logic                 overtime;
    logic [SUM_W-1:0]     limit_sum;
    logic                 pos_sat;
    logic [POS_W-1:0]     pos_calc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            open_reg      <= '0;
            stall_cnt_reg <= '0;
            recovered_reg <= '0;
            current_reg   <= '0;
            valid_reg     <= 1'b0;
            event_reg     <= EV_NONE;
        end else begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            open_reg      <= open_next;
            stall_cnt_reg <= stall_cnt_next;
            recovered_reg <= recovered_next;
            current_reg   <= current_next;
            valid_reg     <= valid_next;
            event_reg     <= event_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        stall_reg <= stall_next;
        fault_reg <= fault_next;
        x_reg     <= x_next;
        n_reg     <= n_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
    end

    // saturating time and stall counters
    assign el_inc    = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TIME_BITS'(1);
    assign sc_new    = !stall_reg ? '0 :
                       (stall_cnt_reg == '1) ? stall_cnt_reg : stall_cnt_reg + STALL_W'(1);
    assign stall_hit = stall_reg && (sc_new >= cfg_debounce);
    assign limit_sum = SUM_W'(cfg_travel) + SUM_W'(cfg_margin);
    assign overtime  = SUM_W'(el_inc) > limit_sum;

    // (T - O) * G, then times 10000 in two partial products
    assign diff    = cfg_travel - open_reg;
    assign x_prod  = XW'(diff) * XW'(cfg_gain);
    assign lo_prod = LP_W'(x_reg[LO_W-1:0]) * LP_W'(POS_FULL);
    assign hi_prod = HP_W'(x_reg[XW-1:LO_W]) * HP_W'(POS_FULL);

    // restoring divide of (n >> 14) by T, one quotient bit a cycle
    assign divisor = {1'b0, cfg_travel};
    assign trial   = {rem_reg, q_reg[QUO_W-1]};

    // open time past travel, zero travel or a quotient above full scale reads as full open
    assign pos_sat  = (cfg_travel == '0) || (open_reg > cfg_travel) ||
                      (q_reg > QUO_W'(POS_FULL));
    assign pos_calc = pos_sat ? POS_FULL : q_reg[POS_W-1:0];

    always_comb begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        open_next      = open_reg;
        stall_cnt_next = stall_cnt_reg;
        recovered_next = recovered_reg;
        current_next   = current_reg;
        valid_next     = valid_reg;
        event_next     = event_reg;
        func_next      = func_reg;
        stall_next     = stall_reg;
        fault_next     = fault_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;

        if (cmd.load) begin
            func_next  = in_func;
            stall_next = in_stall;
            fault_next = in_fault;
        end

        if (cmd.step) begin
            valid_next = 1'b0;
            event_next = EV_NONE;
            if (func_reg) begin
                priority if (!cfg_cal) begin
                    event_next = EV_SKIP;
                end else if (stall_reg || fault_reg) begin
                    phase_next = PH_ERROR;
                end else begin
                    elapsed_next   = '0;
                    stall_cnt_next = '0;
                    phase_next     = PH_OPENING;
                end
            end else begin
                unique case (phase_reg)
                    PH_OPENING: begin
                        elapsed_next = el_inc;
                        if (overtime) begin
                            phase_next = PH_ERROR;
                        end else begin
                            stall_cnt_next = sc_new;
                            if (stall_hit) begin
                                open_next    = el_inc;
                                current_next = POS_FULL;
                                valid_next   = 1'b1;
                                phase_next   = PH_COMPUTE;
                            end
                        end
                    end
                    PH_CLOSING: begin
                        elapsed_next   = el_inc;
                        stall_cnt_next = sc_new;
                        if (stall_hit || (el_inc >= open_reg)) begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE: begin
                        current_next = recovered_reg;
                        valid_next   = 1'b1;
                        event_next   = EV_DONE;
                        phase_next   = PH_IDLE;
                    end
                    PH_ERROR: begin
                        event_next = EV_ERROR;
                        phase_next = PH_IDLE;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        if (cmd.mul) begin
            x_next = x_prod;
        end
        if (cmd.mul_lo) begin
            n_next = NW'(lo_prod);
        end
        if (cmd.mul_hi) begin
            n_next = n_reg + (NW'(hi_prod) << LO_W);
        end
        if (cmd.div_init) begin
            rem_next = n_reg[NW-1:GAIN_FRAC+QUO_W];
            q_next   = n_reg[GAIN_FRAC+QUO_W-1:GAIN_FRAC];
            cnt_next = CNT_W'(QUO_W - 1);
        end
        if (cmd.div_step) begin
            if (trial >= divisor) begin
                rem_next = TIME_BITS'(trial - divisor);
                q_next   = {q_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[TIME_BITS-1:0];
                q_next   = {q_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (cmd.fin) begin
            valid_next     = 1'b1;
            event_next     = EV_NONE;
            recovered_next = pos_calc;
            current_next   = pos_calc;
            if (pos_calc >= POS_DONE) begin
                phase_next = PH_DONE;
            end else begin
                elapsed_next   = '0;
                stall_cnt_next = '0;
                phase_next     = PH_CLOSING;
            end
        end
    end

    assign stat.is_compute = !func_reg && (phase_reg == PH_COMPUTE);
    assign stat.div_last   = (cnt_reg == '0);

    assign result.drive_open     = (phase_reg == PH_OPENING);
    assign result.drive_close    = (phase_reg == PH_CLOSING);
    assign result.phase          = phase_reg;
    assign result.position       = current_reg;
    assign result.position_valid = valid_reg;
    assign result.event_res      = event_reg;

    a_compute_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COMPUTE) |-> (current_reg == POS_FULL))
        else $error("compute phase without full open position");

    a_closing_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CLOSING) |->
            ((recovered_reg < POS_DONE) && (current_reg == recovered_reg)))
        else $error("closing phase with inconsistent recovered position");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && (cfg_travel != '0) && (open_reg <= cfg_travel)) |->
            (rem_reg < cfg_travel))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

### sv/valve_stall_rehome_sequencer_unit.sv
// ----------------------------------------------------------------------------
// valve_stall_rehome_sequencer_unit
// Top level: apb registers, sequencer, datapath and result output register.
// ----------------------------------------------------------------------------
// Each input transfer is a 1 ms tick or a start command with the stall and
// fault samples. Every input gives exactly one result transfer. The tick in
// the compute phase takes longer than a plain tick or start, as it runs the
// two partial products of the position multiply and the 16-step restoring
// divider. A new input is taken once the result of the previous one is in
// the output register, while that result may still wait on the output; the
// block stalls only when a second result is ready before the first one is
// taken. Registers are to be written over apb only while no input is in
// work; the block itself does not enforce it.
`default_nettype none

module valve_stall_rehome_sequencer_unit
    import vsrs_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // apb
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,  // stall_active, fault_active, zero pad
    input  wire logic                  s_tuser,  // func
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [23:0]           m_tdata   // drive_open, drive_close, phase[3],
                                                 // position[14], position_valid,
                                                 // event_res[2], zero pad
);

    localparam int TT_W = (TIME_BITS < TRAVEL_W) ? TIME_BITS : TRAVEL_W;

    logic [TT_W-1:0]       travel_reg;
    logic [MARGIN_W-1:0]   margin_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic                  cal_reg;

    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_wr;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    result_t  dp_result;
    result_t  out_reg;
    logic     m_tvalid_reg;
    logic     out_free;
    logic     out_load;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            travel_reg   <= TT_W'(TRAVEL_RESET);
            margin_reg   <= MARGIN_RESET;
            debounce_reg <= DEBOUNCE_RESET;
            gain_reg     <= GAIN_RESET;
            cal_reg      <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TRAVEL:   travel_reg   <= pwdata[TT_W-1:0];
                REG_MARGIN:   margin_reg   <= pwdata[MARGIN_W-1:0];
                REG_DEBOUNCE: debounce_reg <= pwdata[DEBOUNCE_W-1:0];
                REG_GAIN:     gain_reg     <= pwdata[GAIN_W-1:0];
                REG_CAL:      cal_reg      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRAVEL:   prdata = APB_DATA_W'(travel_reg);
            REG_MARGIN:   prdata = APB_DATA_W'(margin_reg);
            REG_DEBOUNCE: prdata = APB_DATA_W'(debounce_reg);
            REG_GAIN:     prdata = APB_DATA_W'(gain_reg);
            REG_CAL:      prdata = APB_DATA_W'(cal_reg);
            default:      prdata = '0;
        endcase
    end

    vsrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd),
        .stat     (stat)
    );

    vsrs_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_func      (s_tuser),
        .in_stall     (s_tdata[0]),
        .in_fault     (s_tdata[1]),
        .cfg_travel   (TIME_BITS'(travel_reg)),
        .cfg_margin   (margin_reg),
        .cfg_debounce (debounce_reg),
        .cfg_gain     (gain_reg),
        .cfg_cal      (cal_reg),
        .result       (dp_result)
    );

    // output register, refilled in the cycle it drains
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= dp_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.event_res, out_reg.position_valid,
                       out_reg.position, out_reg.phase,
                       out_reg.drive_close, out_reg.drive_open};

endmodule

`default_nettype wire
